/* hdl/esgd_pkg.sv */
// Shared types and constants for the edge swipe gesture detector.
package esgd_pkg;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned CoordW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 12;
  localparam int unsigned CountW = 4;
  localparam int unsigned DirW   = 3;

  localparam logic [CmdW-1:0] CMD_DOWN   = 2'd0;
  localparam logic [CmdW-1:0] CMD_MOTION = 2'd1;
  localparam logic [CmdW-1:0] CMD_UP     = 2'd2;

  localparam logic [DirW-1:0] SIDE_NONE   = 3'd0;
  localparam logic [DirW-1:0] SIDE_LEFT   = 3'd1;
  localparam logic [DirW-1:0] SIDE_RIGHT  = 3'd2;
  localparam logic [DirW-1:0] SIDE_TOP    = 3'd3;
  localparam logic [DirW-1:0] SIDE_BOTTOM = 3'd4;

  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DOCK_EXTENT   = 2'd2;

  localparam logic [CfgW-1:0] SCREEN_WIDTH_RST  = 12'd1920;
  localparam logic [CfgW-1:0] SCREEN_HEIGHT_RST = 12'd1080;
  localparam logic [CfgW-1:0] DOCK_EXTENT_RST   = 12'd0;

  // 12.4 coordinates: one pixel is 16 units
  localparam logic [CoordW-1:0] PIX_FX    = 16'd16;
  localparam logic [CoordW-1:0] MARGIN_FX = 16'd48;
  // minimum travel of 10 pixels is 160 units, squared 25600
  localparam logic [CoordW-1:0] TRAVEL_FX    = 16'd160;
  localparam logic [16:0]       TRAVEL_SQ_FX = 17'd25600;

  localparam logic [CountW-1:0] COUNT_MAX = 4'd15;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [CoordW-1:0] pos_x;
    logic [CoordW-1:0] pos_y;
    logic [TimeW-1:0]  timestamp;
  } req_t;

  typedef struct packed {
    logic              show_multitasking;
    logic [DirW-1:0]   edge_direction;
    logic              touch_active;
    logic [CountW-1:0] finger_count;
  } rsp_t;

  typedef struct packed {
    logic [CfgW-1:0] screen_width;
    logic [CfgW-1:0] screen_height;
    logic [CfgW-1:0] dock_extent;
  } cfg_t;

endpackage

/* hdl/esgd_stream_if.sv */
// Valid/ready stream interface carrying one payload per request.
interface esgd_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/esgd_core.sv */
// Gesture state and single-pass event evaluation.
module esgd_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  esgd_pkg::req_t item_i,
  input  esgd_pkg::cfg_t cfg_i,
  output esgd_pkg::rsp_t rsp_o
);
  import esgd_pkg::*;

  logic [CountW-1:0] fingers_q, fingers_d;
  logic              down_q, down_d;
  logic [CoordW-1:0] start_x_q, start_x_d, start_y_q, start_y_d;
  logic [CoordW-1:0] end_x_q, end_x_d, end_y_q, end_y_d;
  logic [TimeW-1:0]  end_time_q, end_time_d;
  logic [CoordW-1:0] stop_x_q, stop_x_d, stop_y_q, stop_y_d;
  logic [TimeW-1:0]  stop_time_q, stop_time_d;

  logic [CountW-1:0] cnt_inc;
  logic [CoordW-1:0] mx, my, tx, ty;
  logic [7:0]        tx_lo, ty_lo;
  logic [15:0]       sq_x, sq_y;
  logic [16:0]       sq_sum;
  logic              travel_ok;
  logic signed [17:0] right_bound, bottom_bound, sx_s, sy_s;
  logic [DirW-1:0]   edge_dir;
  logic              show;
  logic [DirW-1:0]   dir;

  function automatic logic [CoordW-1:0] abs_diff(logic [CoordW-1:0] a, logic [CoordW-1:0] b);
    abs_diff = (a > b) ? a - b : b - a;
  endfunction

  assign cnt_inc = (fingers_q < COUNT_MAX) ? fingers_q + 4'd1 : fingers_q;

  assign mx = abs_diff(item_i.pos_x, stop_x_q);
  assign my = abs_diff(item_i.pos_y, stop_y_q);

  // travel check: either axis at least 160 units, else exact sum of 8-bit squares
  assign tx     = abs_diff(end_x_q, start_x_q);
  assign ty     = abs_diff(end_y_q, start_y_q);
  assign tx_lo  = tx[7:0];
  assign ty_lo  = ty[7:0];
  assign sq_x   = tx_lo * tx_lo;
  assign sq_y   = ty_lo * ty_lo;
  assign sq_sum = {1'b0, sq_x} + {1'b0, sq_y};
  assign travel_ok = (tx >= TRAVEL_FX) || (ty >= TRAVEL_FX) || (sq_sum >= TRAVEL_SQ_FX);

  assign right_bound  = $signed({2'b00, cfg_i.screen_width, 4'b0000})
                      - $signed({2'b00, MARGIN_FX});
  assign bottom_bound = $signed({2'b00, cfg_i.screen_height, 4'b0000})
                      - $signed({2'b00, MARGIN_FX});
  assign sx_s = $signed({2'b00, start_x_q});
  assign sy_s = $signed({2'b00, start_y_q});

  always_comb begin
    if (start_x_q <= MARGIN_FX) begin
      edge_dir = SIDE_LEFT;
    end else if (sx_s >= right_bound) begin
      edge_dir = SIDE_RIGHT;
    end else if (start_y_q <= MARGIN_FX) begin
      edge_dir = SIDE_TOP;
    end else if (sy_s >= bottom_bound) begin
      edge_dir = SIDE_BOTTOM;
    end else begin
      edge_dir = SIDE_NONE;
    end
  end

  always_comb begin
    fingers_d   = fingers_q;
    down_d      = down_q;
    start_x_d   = start_x_q;
    start_y_d   = start_y_q;
    end_x_d     = end_x_q;
    end_y_d     = end_y_q;
    end_time_d  = end_time_q;
    stop_x_d    = stop_x_q;
    stop_y_d    = stop_y_q;
    stop_time_d = stop_time_q;
    show        = 1'b0;
    dir         = SIDE_NONE;
    case (item_i.command)
      CMD_DOWN: begin
        fingers_d = cnt_inc;
        if (cnt_inc == 4'd1) begin
          start_x_d   = item_i.pos_x;
          start_y_d   = item_i.pos_y;
          end_x_d     = item_i.pos_x;
          end_y_d     = item_i.pos_y;
          end_time_d  = item_i.timestamp;
          down_d      = 1'b1;
          stop_x_d    = item_i.pos_x;
          stop_y_d    = item_i.pos_y;
          stop_time_d = item_i.timestamp;
        end
      end
      CMD_MOTION: begin
        if (fingers_q == 4'd1) begin
          end_x_d    = item_i.pos_x;
          end_y_d    = item_i.pos_y;
          end_time_d = item_i.timestamp;
          if ((mx >= PIX_FX) || (my >= PIX_FX)) begin
            stop_x_d    = item_i.pos_x;
            stop_y_d    = item_i.pos_y;
            stop_time_d = item_i.timestamp;
          end
        end
      end
      CMD_UP: begin
        if (fingers_q != 4'd0) begin
          fingers_d = fingers_q - 4'd1;
        end
        if (fingers_q == 4'd1) begin
          end_time_d = item_i.timestamp;
          if (down_q && travel_ok) begin
            dir = edge_dir;
          end
          show = (dir == SIDE_BOTTOM) && (ty > {cfg_i.dock_extent, 4'b0000})
              && (item_i.timestamp != stop_time_q);
          down_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fingers_q   <= '0;
      down_q      <= 1'b0;
      start_x_q   <= '0;
      start_y_q   <= '0;
      end_x_q     <= '0;
      end_y_q     <= '0;
      end_time_q  <= '0;
      stop_x_q    <= '0;
      stop_y_q    <= '0;
      stop_time_q <= '0;
    end else if (adv_i) begin
      fingers_q   <= fingers_d;
      down_q      <= down_d;
      start_x_q   <= start_x_d;
      start_y_q   <= start_y_d;
      end_x_q     <= end_x_d;
      end_y_q     <= end_y_d;
      end_time_q  <= end_time_d;
      stop_x_q    <= stop_x_d;
      stop_y_q    <= stop_y_d;
      stop_time_q <= stop_time_d;
    end
  end

  assign rsp_o.show_multitasking = show;
  assign rsp_o.edge_direction    = dir;
  assign rsp_o.touch_active      = down_d;
  assign rsp_o.finger_count      = fingers_d;

endmodule

/* hdl/edge_swipe_gesture_detector.sv */
// Top level of the edge swipe gesture detector: handshake stages and configuration.
//
//  channel  | dir | payload                                        | accept
//  req_i    | in  | command, pos_x, pos_y, timestamp               | valid && ready
//  res_o    | out | show_multitasking, edge_direction,            | valid && ready
//           |     | touch_active, finger_count                     |
//  cfg_*    | in  | cfg_idx_i, cfg_data_i                          | cfg_we_i
//
// One request per cycle sustained while results are taken; an accepted request is held
// in the request register, and its result is loaded into the result register.
// The request register feeds the state update and result logic, which load the
// result register; a stalled result holds while one more request waits in the
// request register. Reset clears gesture state and loads default screen geometry.
module edge_swipe_gesture_detector (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  esgd_stream_if.sink                 req_i,
  esgd_stream_if.source               res_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [esgd_pkg::CfgW-1:0]   cfg_data_i
);
  import esgd_pkg::*;

  cfg_t cfg_q;
  req_t req_q;
  logic req_valid_q;
  rsp_t rsp_d, rsp_q;
  logic rsp_valid_q;
  logic adv;

  assign adv         = req_valid_q && (!rsp_valid_q || res_o.ready);
  assign req_i.ready = !req_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= SCREEN_WIDTH_RST;
      cfg_q.screen_height <= SCREEN_HEIGHT_RST;
      cfg_q.dock_extent   <= DOCK_EXTENT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i;
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i;
        REG_DOCK_EXTENT:   cfg_q.dock_extent   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      req_valid_q <= (req_i.valid && req_i.ready) || (req_valid_q && !adv);
      rsp_valid_q <= adv || (rsp_valid_q && !res_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q <= req_i.data;
    end
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

  esgd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (req_q),
    .cfg_i  (cfg_q),
    .rsp_o  (rsp_d)
  );

  assign res_o.valid = rsp_valid_q;
  assign res_o.data  = rsp_q;

endmodule

/* hdl/esgd_checker.sv */
// Port-level assertions for the edge swipe gesture detector, bound to the top level.
module esgd_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 res_valid_i,
  input logic                 res_ready_i,
  input esgd_pkg::rsp_t       res_data_i
);
  import esgd_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("result dropped or changed while stalled");

  a_show_bottom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_data_i.show_multitasking |-> res_data_i.edge_direction == SIDE_BOTTOM)
    else $error("multitasking raised without bottom edge");

  a_dir_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_data_i.edge_direction != SIDE_NONE)
    |-> (res_data_i.finger_count == 4'd0) && !res_data_i.touch_active)
    else $error("edge reported while a finger is still down");

  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_data_i.edge_direction <= SIDE_BOTTOM)
    else $error("edge code out of range");

endmodule

bind edge_swipe_gesture_detector esgd_checker u_esgd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);
